// ===== design/utf8_to_cp1252_transcoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8 to cp1252 transcoder assertion macros
// shared concurrent check forms for the transcoder modules
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP1252_TRANSCODER_MACROS_SVH
`define UTF8_TO_CP1252_TRANSCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UTF8CP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8cp: same-cycle check failed");

// next-cycle implication, disabled during reset
`define UTF8CP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8cp: next-cycle check failed");

`endif

// ===== design/utf8cp_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8cp_pkg
// types, constants and lookup functions of the utf8 to cp1252 transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf8cp_pkg;

  localparam int unsigned MaxSeqBytes = 6;
  localparam int unsigned RawSlots    = 6;
  localparam int unsigned CountW      = 3;
  localparam int unsigned CpW         = 31;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned TabSize     = 27;

  localparam logic [7:0] ReplResetByte = 8'hA4;

  localparam logic [15:0] CpTab [TabSize] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
    16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
  };

  localparam logic [7:0] ByteTab [TabSize] = '{
    8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
  };

  typedef logic [CountW-1:0] count_t;

  // one unit of work for the back end: a mapped code point or a run of raw bytes
  typedef struct packed {
    logic                        mapped;
    logic                        eos;
    count_t                      count;
    logic [RawSlots-1:0][7:0]    raw;
    logic [CpW-1:0]              cp;
  } cmd_t;

  function automatic count_t lead_length(input logic [7:0] b, input count_t max_len);
    count_t n;
    n = '0;
    if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end else if (b[7:2] == 6'b111110) begin
      n = 3'd5;
    end else if (b[7:1] == 7'b1111110) begin
      n = 3'd6;
    end
    if (n > max_len) begin
      n = '0;
    end
    return n;
  endfunction

  function automatic logic [7:0] map_code_point(input logic [CpW-1:0] v,
                                                input logic [7:0] repl);
    logic [7:0] r;
    if (v[CpW-1:8] == '0) begin
      r = v[7:0];
    end else begin
      r = repl;
      for (int i = 0; i < TabSize; i++) begin
        if (v == CpW'(CpTab[i])) begin
          r = ByteTab[i];
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/utf8cp_if.sv =====
// ----------------------------------------------------------------------------
// utf8cp channel interfaces
// valid/ready channels for input bytes and output bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface utf8cp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8cp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/utf8cp_front.sv =====
// ----------------------------------------------------------------------------
// utf8cp_front
// accepts input bytes, tracks the open sequence and issues back end commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp1252_transcoder_macros.svh"

module utf8cp_front #(
  parameter int unsigned MAX_SEQUENCE_BYTES = utf8cp_pkg::MaxSeqBytes
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  utf8cp_in_if.sink              in_i,
  output logic                   push_o,
  output utf8cp_pkg::cmd_t       cmd_o,
  input  wire logic              full_i
);

  localparam int unsigned ContDepth = (MAX_SEQUENCE_BYTES > 2) ? MAX_SEQUENCE_BYTES - 2 : 1;
  localparam int unsigned IdxW      = (ContDepth > 1) ? $clog2(ContDepth) : 1;
  localparam utf8cp_pkg::count_t MaxLen   = utf8cp_pkg::count_t'(MAX_SEQUENCE_BYTES);
  localparam utf8cp_pkg::count_t ContLim  = utf8cp_pkg::count_t'(ContDepth);
  localparam int unsigned CpW       = utf8cp_pkg::CpW;
  localparam int unsigned RawSlots  = utf8cp_pkg::RawSlots;

  logic [7:0]          lead_q, lead_d;
  utf8cp_pkg::count_t  exp_len_q, exp_len_d;
  utf8cp_pkg::count_t  rc_q, rc_d;
  logic [CpW-1:0]      cp_q, cp_d;
  logic [7:0]          cont_q [ContDepth];

  logic [7:0]          b;
  logic                eos;
  logic                acc;
  logic                open;
  logic                cont_hit;
  logic                complete;
  logic                cont_wr;
  utf8cp_pkg::count_t  len;
  utf8cp_pkg::count_t  rc_inc;
  utf8cp_pkg::count_t  flush_n;
  utf8cp_pkg::count_t  count;
  logic [CpW-1:0]      cp_new;
  logic [7:0]          cont_ext [RawSlots-1];

  assign b        = in_i.in_byte;
  assign eos      = in_i.end_of_string;
  assign in_i.ready = !full_i;
  assign acc      = in_i.valid && !full_i;

  assign open     = (exp_len_q != '0);
  assign cont_hit = open && (b[7:6] == 2'b10);
  assign rc_inc   = rc_q + 3'd1;
  assign complete = cont_hit && ((4'(rc_inc) + 4'd1) >= 4'(exp_len_q));
  assign cp_new   = {cp_q[CpW-7:0], b[5:0]};
  assign len      = utf8cp_pkg::lead_length(b, MaxLen);
  assign cont_wr  = acc && cont_hit && !complete && !eos && (rc_q < ContLim);

  // buffered continuations, with the current byte standing in past the buffer
  for (genvar j = 0; j < RawSlots - 1; j++) begin : g_cont
    if (j < ContDepth) begin : g_buf
      assign cont_ext[j] = cont_q[j];
    end else begin : g_none
      assign cont_ext[j] = b;
    end
  end

  always_comb begin
    flush_n = open ? (rc_q + 3'd1) : '0;
    if (cont_hit) begin
      count = eos ? (rc_q + 3'd2) : '0;
    end else begin
      count = flush_n + utf8cp_pkg::count_t'((len == '0) || eos);
    end

    cmd_o        = '0;
    cmd_o.mapped = complete;
    cmd_o.eos    = eos;
    cmd_o.cp     = cp_new;
    cmd_o.count  = complete ? 3'd1 : count;
    // raw run: lead (or the current byte if no sequence is open), buffered continuations, then the current byte
    cmd_o.raw[0] = open ? lead_q : b;
    for (int i = 1; i < RawSlots; i++) begin
      cmd_o.raw[i] = (utf8cp_pkg::count_t'(i - 1) < rc_q) ? cont_ext[i-1] : b;
    end
    push_o = acc && (complete || (count != '0));
  end

  always_comb begin
    lead_d    = lead_q;
    exp_len_d = exp_len_q;
    rc_d      = rc_q;
    cp_d      = cp_q;
    if (acc) begin
      if (cont_hit) begin
        if (complete || eos) begin
          exp_len_d = '0;
          rc_d      = '0;
          cp_d      = '0;
        end else begin
          rc_d = rc_inc;
          cp_d = cp_new;
        end
      end else if ((len != '0) && !eos) begin
        lead_d    = b;
        exp_len_d = len;
        rc_d      = '0;
        cp_d      = CpW'(b & (8'h7F >> len));
      end else begin
        exp_len_d = '0;
        rc_d      = '0;
        cp_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      exp_len_q <= '0;
      rc_q      <= '0;
      cp_q      <= '0;
    end else begin
      lead_q    <= lead_d;
      exp_len_q <= exp_len_d;
      rc_q      <= rc_d;
      cp_q      <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cont_wr) begin
      cont_q[rc_q[IdxW-1:0]] <= b;
    end
  end

  // an open sequence never holds enough bytes to be complete
  `UTF8CP_ASSERT_IMP(a_open_short, clk_i, rst_ni, open, (4'(rc_q) + 4'd1) < 4'(exp_len_q))

endmodule

`default_nettype wire

// ===== design/utf8cp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// utf8cp_cmd_queue
// short command queue between the front end and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp1252_transcoder_macros.svh"

module utf8cp_cmd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire utf8cp_pkg::cmd_t  cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output utf8cp_pkg::cmd_t       cmd_o
);

  localparam int unsigned Depth = utf8cp_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  utf8cp_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // depth is a power of two, pointers wrap on their own
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // front end must hold off while the queue is full
  `UTF8CP_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o)
  `UTF8CP_ASSERT_NXT(a_drain_last, clk_i, rst_ni, do_pop && !do_push && (cnt_q == CntW'(1)), empty_o)

endmodule

`default_nettype wire

// ===== design/utf8cp_back.sv =====
// ----------------------------------------------------------------------------
// utf8cp_back
// executes commands one output byte per cycle, while the receiver is ready, into a registered output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp1252_transcoder_macros.svh"

module utf8cp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              empty_i,
  input  wire utf8cp_pkg::cmd_t  cmd_i,
  output logic                   pop_o,
  utf8cp_out_if.source           out_o
);

  logic [7:0]          repl_q;
  logic                busy_q;
  utf8cp_pkg::cmd_t    cmd_q;
  utf8cp_pkg::count_t  idx_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                run_last_q;
  logic                string_last_q;

  logic                load;
  logic                cur_last;
  logic [7:0]          cur_byte;

  assign load     = !out_valid_q || out_o.ready;
  assign cur_last = cmd_q.mapped || ((idx_q + 3'd1) == cmd_q.count);
  assign cur_byte = cmd_q.mapped ? utf8cp_pkg::map_code_point(cmd_q.cp, repl_q)
                                 : cmd_q.raw[idx_q];
  // take the next command while the last byte of the current one goes out
  assign pop_o    = load && !empty_i && (!busy_q || cur_last);

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.string_last = string_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q      <= utf8cp_pkg::ReplResetByte;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= busy_q;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load && busy_q) begin
        if (cur_last) begin
          busy_q <= 1'b0;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (load && busy_q) begin
      out_byte_q    <= cur_byte;
      run_last_q    <= cur_last;
      string_last_q <= cur_last && cmd_q.eos;
    end
  end

  `UTF8CP_ASSERT_IMP(a_raw_idx, clk_i, rst_ni, busy_q && !cmd_q.mapped, (cmd_q.count != '0) && (idx_q < cmd_q.count))
  `UTF8CP_ASSERT_IMP(a_mapped_idx, clk_i, rst_ni, busy_q && cmd_q.mapped, idx_q == '0)
  `UTF8CP_ASSERT_IMP(a_eos_on_last, clk_i, rst_ni, out_valid_q && string_last_q, run_last_q)

endmodule

`default_nettype wire

// ===== design/utf8_to_cp1252_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder
// utf-8 byte stream to windows-1252 byte stream
// ----------------------------------------------------------------------------
// in_i carries one utf-8 byte per item with an end of string flag; out_o
// carries windows-1252 bytes with run_last on the last byte caused by an
// input item and string_last on the final byte of the string.
// cfg_we_i/cfg_wdata_i write the replacement byte used for code points above
// 0xff that have no cp1252 slot; write it only while the block is idle.
// the first byte of an item passes the command queue, the back end command
// register and the output register. the back end emits one byte per cycle
// while the receiver is ready, and an item produces 0 to 6 bytes; a broken or
// unfinished sequence flushes up to 6 raw bytes.
// the 2-entry command queue lets input run ahead while output drains.
// reset closes any open sequence, empties queue and output register and sets
// the replacement byte to 0xa4.
// a stalled receiver holds the output byte; once the queue fills, in_i.ready
// drops until the back end takes a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_cp1252_transcoder #(
  parameter int unsigned MAX_SEQUENCE_BYTES = utf8cp_pkg::MaxSeqBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  utf8cp_in_if.sink        in_i,
  utf8cp_out_if.source     out_o
);

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  utf8cp_pkg::cmd_t  front_cmd;
  utf8cp_pkg::cmd_t  queue_cmd;

  utf8cp_front #(
    .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (front_cmd),
    .full_i (full)
  );

  utf8cp_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (queue_cmd)
  );

  utf8cp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
